>>> rtl/llbb_pkg.sv
`timescale 1ns / 1ps

package llbb_pkg;

  localparam int unsigned IndexW     = 16;
  localparam int unsigned BytesW     = 32;
  localparam int unsigned WorkerW    = 4;
  localparam int unsigned LoadW      = 42;
  localparam int unsigned CountW     = 5;
  // Token worker index, wide enough for the largest supported chain (64 cells)
  localparam int unsigned TokIdxW    = 6;
  localparam int unsigned MaxWorkers = 16;

  localparam logic [CountW-1:0] CountReset = CountW'(1);

  typedef struct packed {
    logic [IndexW-1:0] entry_index;
    logic [BytesW-1:0] entry_bytes;
    logic              batch_start;
  } llbb_in_t;

  typedef struct packed {
    logic [IndexW-1:0]  assigned_index;
    logic [WorkerW-1:0] assigned_worker;
    logic [LoadW-1:0]   worker_load;
  } llbb_out_t;

  // Search token handed from cell to cell
  typedef struct packed {
    logic               valid;
    logic               found;
    logic [TokIdxW-1:0] idx;
    logic [LoadW-1:0]   val;
  } llbb_tok_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } llbb_state_e;

endpackage

>>> rtl/llbb_cell.sv
`timescale 1ns / 1ps

module llbb_cell import llbb_pkg::*; #(
  parameter int unsigned CellIdx = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  logic             wr_i,
  input  logic [LoadW-1:0] wr_data_i,
  input  logic             active_i,
  input  llbb_tok_t        tok_i,
  output llbb_tok_t        tok_o
);

  logic [LoadW-1:0] total_q, total_d;
  llbb_tok_t        tok_q, tok_d;

  always_comb begin
    total_d = total_q;
    if (clear_i) begin
      total_d = '0;
    end else if (wr_i) begin
      total_d = wr_data_i;
    end
  end

  // Strict less-than keeps the earlier (lower numbered) worker on a tie
  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid && active_i && (!tok_i.found || (total_q < tok_i.val))) begin
      tok_d.found = 1'b1;
      tok_d.idx   = TokIdxW'(CellIdx);
      tok_d.val   = total_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      tok_q   <= '0;
    end else begin
      total_q <= total_d;
      tok_q   <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

>>> rtl/least_loaded_byte_balancer_core.sv
`timescale 1ns / 1ps
// Least-loaded byte balancer.
// Input channel (in_valid_i / in_ready_o / in_data_i): one transaction per
// archive entry, carrying its index, byte size and a batch start flag. The
// entry goes to the worker with the smallest running byte total (lowest
// number on a tie) and that total grows by the entry size, saturating.
// Output channel (out_valid_o / out_ready_i / out_data_o): one transaction
// per entry with the index, chosen worker and that worker's new total.
// Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i): worker count,
// always ready; 0 behaves as 1, above MAX_WORKERS as MAX_WORKERS. Write it
// only while the block is idle.
// Timing: a search token walks the chain of MAX_WORKERS cells, one cell per
// cycle, then the update step writes the winner once the output slot is
// free. A new entry is taken only after the previous one has left the
// update step.
// Batch start clears every total in the accept cycle.
// Reset: all totals zero, worker count 1, both channels empty.
// Receiver stall: the result sits in the output register; the next entry is
// still accepted and scanned, and waits in the update step for the slot.

module least_loaded_byte_balancer_core import llbb_pkg::*; #(
  parameter int unsigned MAX_WORKERS = MaxWorkers
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  llbb_in_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output llbb_out_t         out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CountW-1:0] cfg_data_i
);

  localparam int unsigned CntW = $clog2(MAX_WORKERS + 1);
  localparam int unsigned CmpW = (CntW > CountW) ? CntW : CountW;

  // Control
  llbb_state_e state_q, state_d;
  logic        in_fire, upd_fire, start_q;
  logic        out_valid_q;
  llbb_out_t   out_data_q;

  // Config and per-entry latches
  logic [CountW-1:0] count_q;
  logic [CntW-1:0]   n_q;
  logic [CmpW-1:0]   cnt_ext;
  logic [CntW-1:0]   n_d;
  llbb_in_t          item_q;
  llbb_tok_t         best_q;

  // Chain
  llbb_tok_t          tok [MAX_WORKERS+1];
  logic [MAX_WORKERS-1:0] wr_en;
  logic [LoadW:0]     sum_raw;
  logic [LoadW-1:0]   sum_sat;

  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CountReset;
    end else if (cfg_valid_i) begin
      count_q <= cfg_data_i;
    end
  end

  // Active worker count, clamped to 1..MAX_WORKERS
  always_comb begin
    cnt_ext = CmpW'(count_q);
    if (cnt_ext == '0) begin
      n_d = CntW'(1);
    end else if (cnt_ext > CmpW'(MAX_WORKERS)) begin
      n_d = CntW'(MAX_WORKERS);
    end else begin
      n_d = CntW'(cnt_ext);
    end
  end

  // Next-state logic
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (tok[MAX_WORKERS].valid) state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output decode
  always_comb begin
    in_ready_o = 1'b0;
    upd_fire   = 1'b0;
    case (state_q)
      ST_IDLE:   in_ready_o = 1'b1;
      ST_SCAN:   ;
      ST_UPDATE: upd_fire = !out_valid_q || out_ready_i;
      default:   ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= in_fire;
      if (upd_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_data_i;
      n_q    <= n_d;
    end
    if (tok[MAX_WORKERS].valid) begin
      best_q <= tok[MAX_WORKERS];
    end
    if (upd_fire) begin
      out_data_q.assigned_index  <= item_q.entry_index;
      // Worker number is reported modulo 16, as the field is four bits
      out_data_q.assigned_worker <= best_q.idx[WorkerW-1:0];
      out_data_q.worker_load     <= sum_sat;
    end
  end

  // Saturating add of the entry size onto the winner's total
  assign sum_raw = {1'b0, best_q.val} + (LoadW + 1)'(item_q.entry_bytes);
  assign sum_sat = sum_raw[LoadW] ? {LoadW{1'b1}} : sum_raw[LoadW-1:0];

  // Token enters at cell 0 the cycle after acceptance, after any clear
  assign tok[0] = {start_q, {($bits(llbb_tok_t) - 1){1'b0}}};

  for (genvar i = 0; i < MAX_WORKERS; i++) begin : g_cell
    assign wr_en[i] = upd_fire && (best_q.idx == TokIdxW'(i));

    llbb_cell #(
      .CellIdx (i)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .clear_i   (in_fire && in_data_i.batch_start),
      .wr_i      (wr_en[i]),
      .wr_data_i (sum_sat),
      .active_i  (CntW'(i) < n_q),
      .tok_i     (tok[i]),
      .tok_o     (tok[i+1])
    );
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTH
  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(wr_en))
    else $error("more than one worker total written");

  a_tok_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[MAX_WORKERS].valid |-> (state_q == ST_SCAN))
    else $error("search token left the chain outside a scan");

  a_tok_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[MAX_WORKERS].valid |-> tok[MAX_WORKERS].found)
    else $error("scan finished without a winner");

  a_upd_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_fire |=> out_valid_o)
    else $error("update did not load the output register");
`endif

endmodule
